@@ hdl/rvalu_pkg.sv @@
package rvalu_pkg;

  localparam int unsigned XLEN = 32;
  localparam int unsigned DivSteps = XLEN;

  typedef logic [XLEN-1:0] word_t;

  typedef enum logic [2:0] {
    BASE_ADD  = 3'd0,
    BASE_SLL  = 3'd1,
    BASE_SLT  = 3'd2,
    BASE_SLTU = 3'd3,
    BASE_XOR  = 3'd4,
    BASE_SR   = 3'd5,
    BASE_OR   = 3'd6,
    BASE_AND  = 3'd7
  } base_op_e;

  typedef enum logic [2:0] {
    MD_MUL    = 3'd0,
    MD_MULH   = 3'd1,
    MD_MULHSU = 3'd2,
    MD_MULHU  = 3'd3,
    MD_DIV    = 3'd4,
    MD_DIVU   = 3'd5,
    MD_REM    = 3'd6,
    MD_REMU   = 3'd7
  } md_op_e;

  typedef struct packed {
    logic  is_div;
    logic  want_rem;
    logic  neg_q;
    logic  neg_r;
    logic  div_zero;
    word_t side;
    word_t orig_a;
    word_t rem;
    word_t quo;
    word_t dvsr;
  } lane_t;

endpackage

@@ hdl/rvalu_base.sv @@
module rvalu_base import rvalu_pkg::*; (
  input  logic [2:0] kind_i,
  input  logic       reg_form_i,
  input  logic       alt_bit_i,
  input  word_t      a_i,
  input  word_t      b_i,
  output word_t      result_o
);

  logic [4:0] shamt;

  assign shamt = b_i[4:0];

  always_comb begin
    case (base_op_e'(kind_i))
      BASE_ADD:  result_o = (reg_form_i && alt_bit_i) ? a_i - b_i : a_i + b_i;
      BASE_SLL:  result_o = a_i << shamt;
      BASE_SLT:  result_o = {{(XLEN-1){1'b0}}, ($signed(a_i) < $signed(b_i))};
      BASE_SLTU: result_o = {{(XLEN-1){1'b0}}, (a_i < b_i)};
      BASE_XOR:  result_o = a_i ^ b_i;
      BASE_SR:   result_o = alt_bit_i ? word_t'($signed(a_i) >>> shamt) : a_i >> shamt;
      BASE_OR:   result_o = a_i | b_i;
      BASE_AND:  result_o = a_i & b_i;
      default:   result_o = '0;
    endcase
  end

endmodule

@@ hdl/rvalu_div_stage.sv @@
module rvalu_div_stage import rvalu_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  lane_t lane_i,
  output logic  valid_o,
  output lane_t lane_o
);

  logic        valid_q;
  lane_t       lane_d, lane_q;
  logic [XLEN:0] trial;
  logic [XLEN:0] diff;

  always_comb begin
    lane_d = lane_i;
    trial  = {lane_i.rem, lane_i.quo[XLEN-1]};
    diff   = trial - {1'b0, lane_i.dvsr};
    if (!diff[XLEN]) begin
      lane_d.rem = diff[XLEN-1:0];
      lane_d.quo = {lane_i.quo[XLEN-2:0], 1'b1};
    end else begin
      lane_d.rem = trial[XLEN-1:0];
      lane_d.quo = {lane_i.quo[XLEN-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    lane_q <= lane_d;
  end

  assign valid_o = valid_q;
  assign lane_o  = lane_q;

endmodule

@@ hdl/rv32im_integer_alu.sv @@
// RV32IM execute unit, fully pipelined.
// Input: drive start with kind_i, use_muldiv_i, reg_form_i, alt_bit_i,
// operand_a_i and operand_b_i; a beat is taken at each clock edge where
// start is high and busy is low. busy is always low, so one beat
// can be issued every cycle.
// Output: each beat returns one result on result_o, flagged by done_o for
// exactly one cycle, in issue order. The receiver cannot stall.
// Pipeline: every operation passes one operand/multiply stage, one
// product-fixup and divide-setup stage, 32 radix-2 restoring divide stages
// (one quotient bit each), one sign-fixup output stage. All operations
// travel the same pipe so order is kept.
// Throughput: one beat per cycle.
// Reset: clears all valid bits; results in flight are dropped and done_o
// stays low until new beats come out.
module rv32im_integer_alu import rvalu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] kind_i,
  input  logic       use_muldiv_i,
  input  logic       reg_form_i,
  input  logic       alt_bit_i,
  input  word_t      operand_a_i,
  input  word_t      operand_b_i,
  output logic       done_o,
  output word_t      result_o
);

  word_t             base_res;
  logic              p_valid_q;
  logic              p_md_q;
  logic [2:0]        p_kind_q;
  word_t             p_base_q, p_a_q, p_b_q;
  logic [2*XLEN-1:0] p_prod_q;

  word_t hi, mul_res;
  logic  sgn;
  lane_t lane_init;

  logic  valid [0:DivSteps+1];
  lane_t lane  [0:DivSteps+1];

  lane_t fin;
  word_t quo_f, rem_f, res_d;
  logic  done_q;
  word_t result_q;

  assign busy = 1'b0;

  rvalu_base u_base (
    .kind_i     (kind_i),
    .reg_form_i (reg_form_i),
    .alt_bit_i  (alt_bit_i),
    .a_i        (operand_a_i),
    .b_i        (operand_b_i),
    .result_o   (base_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else begin
      p_valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    p_md_q   <= use_muldiv_i;
    p_kind_q <= kind_i;
    p_base_q <= base_res;
    p_a_q    <= operand_a_i;
    p_b_q    <= operand_b_i;
    p_prod_q <= operand_a_i * operand_b_i;
  end

  always_comb begin
    hi = p_prod_q[2*XLEN-1:XLEN];
    case (md_op_e'(p_kind_q))
      MD_MUL:    mul_res = p_prod_q[XLEN-1:0];
      MD_MULH:   mul_res = hi - (p_a_q[XLEN-1] ? p_b_q : '0)
                              - (p_b_q[XLEN-1] ? p_a_q : '0);
      MD_MULHSU: mul_res = hi - (p_a_q[XLEN-1] ? p_b_q : '0);
      default:   mul_res = hi;
    endcase
    sgn                = !p_kind_q[0];
    lane_init.is_div   = p_md_q && p_kind_q[2];
    lane_init.want_rem = p_kind_q[1];
    lane_init.neg_q    = sgn && (p_a_q[XLEN-1] ^ p_b_q[XLEN-1]);
    lane_init.neg_r    = sgn && p_a_q[XLEN-1];
    lane_init.div_zero = (p_b_q == '0);
    lane_init.side     = (p_md_q && !p_kind_q[2]) ? mul_res : p_base_q;
    lane_init.orig_a   = p_a_q;
    lane_init.rem      = '0;
    lane_init.quo      = (sgn && p_a_q[XLEN-1]) ? word_t'(-p_a_q) : p_a_q;
    lane_init.dvsr     = (sgn && p_b_q[XLEN-1]) ? word_t'(-p_b_q) : p_b_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid[0] <= 1'b0;
    end else begin
      valid[0] <= p_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    lane[0] <= lane_init;
  end

  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    rvalu_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid[i]),
      .lane_i  (lane[i]),
      .valid_o (valid[i+1]),
      .lane_o  (lane[i+1])
    );
  end

  assign valid[DivSteps+1] = valid[DivSteps];
  assign lane[DivSteps+1]  = lane[DivSteps];

  always_comb begin
    fin   = lane[DivSteps+1];
    quo_f = fin.neg_q ? word_t'(-fin.quo) : fin.quo;
    rem_f = fin.neg_r ? word_t'(-fin.rem) : fin.rem;
    if (fin.div_zero) begin
      quo_f = '1;
      rem_f = fin.orig_a;
    end
    if (fin.is_div) begin
      res_d = fin.want_rem ? rem_f : quo_f;
    end else begin
      res_d = fin.side;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid[DivSteps+1];
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule
